>>> design/gvi_pkg.sv
`timescale 1ns / 1ps
package gvi_pkg;

    localparam int GridWidthDef  = 32;
    localparam int GridHeightDef = 32;
    localparam int ValueBitsDef  = 16;

    localparam logic [2:0] FUNC_SET_WALL   = 3'd0;
    localparam logic [2:0] FUNC_CLEAR_WALL = 3'd1;
    localparam logic [2:0] FUNC_WRITE_CELL = 3'd2;
    localparam logic [2:0] FUNC_RELAX      = 3'd3;
    localparam logic [2:0] FUNC_QUERY      = 3'd4;

    localparam logic [1:0] CFG_STRAIGHT = 2'd0;
    localparam logic [1:0] CFG_DIAGONAL = 2'd1;
    localparam logic [1:0] CFG_FLOOR    = 2'd2;

    localparam logic [3:0] DIR_NONE = 4'd8;

    typedef struct packed {
        logic [2:0]         func;
        logic [4:0]         cell_x;
        logic [4:0]         cell_y;
        logic signed [15:0] reward;
        logic               goal_flag;
    } t_req;

    typedef struct packed {
        logic signed [15:0] cell_value;
        logic [3:0]         direction;
        logic [15:0]        sweep_count;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_DECODE,
        ST_WRITE,
        ST_GATHER,
        ST_EVAL,
        ST_WB,
        ST_NEXT,
        ST_RESULT,
        ST_OUT
    } t_state;

endpackage

>>> design/grid_value_iteration_engine_top.sv
`timescale 1ns / 1ps
// Grid value iteration engine. All cell state (wall, goal, reward, value) lives in one
// synchronous memory with one write port and one registered read port; a cell's eight
// neighbors and itself are fetched one word per cycle. After reset a clearing pass over
// all GRID_WIDTH*GRID_HEIGHT cells initializes the memory before the first request is taken.
// Wall, reward and goal writes to an interior cell read the center word and write it back;
// a query of an interior cell does nine reads, then eight compare steps; border writes and
// queries and unused codes go straight to the result. A relax repeats sweeps over all
// interior cells until no value changes (at most 65535 sweeps). One request is worked on
// at a time; a finished result sits in an output register while the next request is taken.
module grid_value_iteration_engine_top
    import gvi_pkg::*;
#(
    parameter int GRID_WIDTH  = GridWidthDef,
    parameter int GRID_HEIGHT = GridHeightDef,
    parameter int VALUE_BITS  = ValueBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_req        i_req,
    output logic        o_valid,
    input  logic        i_ready,
    output t_rsp        o_rsp,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int XB    = (GRID_WIDTH  > 1) ? $clog2(GRID_WIDTH)  : 1;
    localparam int YB    = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int AB    = $clog2(CELLS);
    localparam int VB    = VALUE_BITS;
    localparam int WB    = 2 + 2 * VB;
    localparam int EB    = ((VB > 13) ? VB : 13) + 3;
    localparam logic signed [EB-1:0] VMAX = EB'((64'sd1 <<< (VB - 1)) - 1);
    localparam logic signed [EB-1:0] VMIN = -VMAX - EB'(1);

    // word: {wall, goal, reward, value}
    logic [WB-1:0] mem [CELLS];
    logic [WB-1:0] r_rd;
    logic          mem_we;
    logic [AB-1:0] mem_wa, mem_ra;
    logic [WB-1:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[mem_ra];
    end

    t_state r_state, n_state;
    logic [11:0] r_scost, r_dcost;
    logic signed [VB-1:0] r_floor;
    t_req r_req, n_req;
    logic r_ovalid, n_ovalid;
    t_rsp r_rsp, n_rsp;
    logic [XB-1:0] r_x, n_x;
    logic [YB-1:0] r_y, n_y;
    logic [3:0] r_k, n_k;
    logic [8:0] r_open, n_open;
    logic [VB-1:0] r_val [9];
    logic [VB-1:0] n_val [9];
    logic r_goal, n_goal, r_wall, n_wall;
    logic signed [VB-1:0] r_rew, n_rew;
    logic signed [EB-1:0] r_best, n_best;
    logic [3:0] r_dir, n_dir;
    logic r_chg, n_chg;
    logic [15:0] r_sweeps, n_sweeps;
    logic r_relax, n_relax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_ovalid <= 1'b0;
            r_x      <= '0;
            r_y      <= '0;
            r_scost  <= 12'd10;
            r_dcost  <= 12'd14;
            r_floor  <= (VB >= 16) ? VB'(-32768) : VMIN[VB-1:0];
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_x      <= n_x;
            r_y      <= n_y;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_STRAIGHT: r_scost <= i_cfg_data[11:0];
                    CFG_DIAGONAL: r_dcost <= i_cfg_data[11:0];
                    CFG_FLOOR: begin
                        if (VB >= 16) begin
                            r_floor <= VB'($signed(i_cfg_data));
                        end else if ($signed(i_cfg_data) < 16'(VMIN)) begin
                            r_floor <= VMIN[VB-1:0];
                        end else if ($signed(i_cfg_data) > 16'(VMAX)) begin
                            r_floor <= VMAX[VB-1:0];
                        end else begin
                            r_floor <= VB'($signed(i_cfg_data));
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req; r_rsp <= n_rsp; r_k <= n_k;
        r_open <= n_open; r_val <= n_val; r_goal <= n_goal; r_wall <= n_wall;
        r_rew <= n_rew; r_best <= n_best; r_dir <= n_dir; r_chg <= n_chg;
        r_sweeps <= n_sweeps; r_relax <= n_relax;
    end

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovalid;
    assign o_rsp       = r_rsp;
    assign o_ready     = (r_state == ST_IDLE);

    // neighbor k: 0 center,1 up,2 right,3 down,4 left,5 ur,6 dr,7 dl,8 ul
    logic signed [2:0] dxk, dyk;
    always_comb begin
        case (r_k)
            4'd1: begin dxk = 3'sd0;  dyk = -3'sd1; end
            4'd2: begin dxk = 3'sd1;  dyk = 3'sd0;  end
            4'd3: begin dxk = 3'sd0;  dyk = 3'sd1;  end
            4'd4: begin dxk = -3'sd1; dyk = 3'sd0;  end
            4'd5: begin dxk = 3'sd1;  dyk = -3'sd1; end
            4'd6: begin dxk = 3'sd1;  dyk = 3'sd1;  end
            4'd7: begin dxk = -3'sd1; dyk = 3'sd1;  end
            4'd8: begin dxk = -3'sd1; dyk = -3'sd1; end
            default: begin dxk = 3'sd0; dyk = 3'sd0; end
        endcase
    end

    logic [XB:0] nx;
    logic [YB:0] ny;
    logic [AB-1:0] addr_k, addr_c;
    assign nx = {1'b0, r_x} + {{(XB-2){dxk[2]}}, dxk};
    assign ny = {1'b0, r_y} + {{(YB-2){dyk[2]}}, dyk};
    assign addr_k = AB'(ny[YB-1:0] * GRID_WIDTH + nx[XB-1:0]);
    assign addr_c = AB'(r_y * GRID_WIDTH + r_x);

    logic clr_border;
    assign clr_border = (r_x == '0) || (r_y == '0) ||
                        (32'(r_x) == GRID_WIDTH - 1) || (32'(r_y) == GRID_HEIGHT - 1);

    logic in_inside, in_interior;
    assign in_inside = (32'(r_req.cell_x) < GRID_WIDTH) && (32'(r_req.cell_y) < GRID_HEIGHT);
    assign in_interior = in_inside && (r_req.cell_x != '0) && (r_req.cell_y != '0) &&
                         (32'(r_req.cell_x) < GRID_WIDTH - 1) &&
                         (32'(r_req.cell_y) < GRID_HEIGHT - 1);

    logic signed [VB-1:0] rew_sat;
    always_comb begin
        if (VB >= 16) begin
            rew_sat = VB'(r_req.reward);
        end else if (EB'(r_req.reward) > VMAX) begin
            rew_sat = VMAX[VB-1:0];
        end else if (EB'(r_req.reward) < VMIN) begin
            rew_sat = VMIN[VB-1:0];
        end else begin
            rew_sat = VB'(r_req.reward);
        end
    end

    // candidate for eval step k (1..8)
    logic usable;
    logic signed [EB-1:0] cand, vk;
    logic [11:0] costk;
    always_comb begin
        case (r_k)
            4'd5: usable = r_open[5] && r_open[1] && r_open[2];
            4'd6: usable = r_open[6] && r_open[2] && r_open[3];
            4'd7: usable = r_open[7] && r_open[3] && r_open[4];
            4'd8: usable = r_open[8] && r_open[4] && r_open[1];
            default: usable = r_open[r_k];
        endcase
        costk = (r_k >= 4'd5) ? r_dcost : r_scost;
        vk    = EB'($signed(r_val[r_k]));
        cand  = r_relax ? (vk - EB'({1'b0, costk}) + EB'(r_rew)) : vk;
    end

    logic signed [EB-1:0] best_sat;
    assign best_sat = (r_best > VMAX) ? VMAX : ((r_best < VMIN) ? VMIN : r_best);

    always_comb begin
        n_state = r_state; n_ovalid = r_ovalid; n_req = r_req;
        n_rsp = r_rsp; n_x = r_x; n_y = r_y; n_k = r_k; n_open = r_open; n_val = r_val;
        n_goal = r_goal; n_wall = r_wall; n_rew = r_rew; n_best = r_best; n_dir = r_dir;
        n_chg = r_chg; n_sweeps = r_sweeps; n_relax = r_relax;
        mem_we = 1'b0; mem_wa = addr_c; mem_wd = r_rd; mem_ra = addr_k;
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wd = {clr_border, 1'b0, {VB{1'b0}}, {VB{1'b0}}};
                n_x    = r_x + 1'b1;
                if (32'(r_x) == GRID_WIDTH - 1) begin
                    n_x = '0;
                    n_y = r_y + 1'b1;
                    if (32'(r_y) == GRID_HEIGHT - 1) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_IDLE: begin
                if (i_valid && o_ready) begin
                    n_req = i_req;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_x = XB'(r_req.cell_x);
                n_y = YB'(r_req.cell_y);
                n_sweeps = '0;
                n_dir = DIR_NONE;
                n_k = '0;
                case (r_req.func)
                    FUNC_SET_WALL, FUNC_CLEAR_WALL, FUNC_WRITE_CELL:
                        n_state = in_interior ? ST_WRITE : ST_RESULT;
                    FUNC_QUERY: begin
                        n_relax = 1'b0;
                        n_state = in_interior ? ST_GATHER : ST_RESULT;
                    end
                    FUNC_RELAX: begin
                        n_relax = 1'b1;
                        n_x = XB'(1); n_y = YB'(1); n_chg = 1'b0;
                        n_state = ST_GATHER;
                    end
                    default: n_state = ST_RESULT;
                endcase
                mem_ra = addr_c;
            end
            ST_WRITE: begin
                // center read issued in the k=0 step, used for the write in the k=1 step
                if (r_k == '0) begin
                    mem_ra = addr_c;
                    n_k = 4'd1;
                end else begin
                    mem_we = 1'b1;
                    mem_wd = r_rd;
                    case (r_req.func)
                        FUNC_SET_WALL:   mem_wd[WB-1] = 1'b1;
                        FUNC_CLEAR_WALL: mem_wd[WB-1] = 1'b0;
                        default: begin
                            mem_wd[WB-2] = r_req.goal_flag;
                            mem_wd[2*VB-1:VB] = rew_sat;
                        end
                    endcase
                    n_state = ST_RESULT;
                end
            end
            ST_GATHER: begin
                // read k issued this cycle, data arrives next cycle as k-1
                mem_ra = addr_k;
                if (r_k != '0) begin
                    n_open[r_k - 1'b1] = !r_rd[WB-1];
                    n_val[r_k - 1'b1] = r_rd[VB-1:0];
                    if (r_k == 4'd1) begin
                        n_wall = r_rd[WB-1];
                        n_goal = r_rd[WB-2];
                        n_rew  = $signed(r_rd[2*VB-1:VB]);
                    end
                end
                if (r_k == 4'd9) begin
                    n_k = 4'd1;
                    n_best = EB'(r_floor);
                    n_dir = DIR_NONE;
                    n_state = ST_EVAL;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_EVAL: begin
                if (usable && cand > r_best) begin
                    n_best = cand;
                    n_dir = r_k - 1'b1;
                end
                if (r_k == 4'd8) begin
                    n_state = r_relax ? ST_WB : ST_RESULT;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_WB: begin
                n_dir = DIR_NONE;
                if (!r_wall) begin
                    mem_we = 1'b1;
                    mem_wd = {r_wall, r_goal, r_rew,
                              r_goal ? r_rew : best_sat[VB-1:0]};
                    if (mem_wd[VB-1:0] != r_val[0]) begin
                        n_chg = 1'b1;
                    end
                end
                n_state = ST_NEXT;
            end
            ST_NEXT: begin
                n_k = '0;
                n_state = ST_GATHER;
                if (32'(r_x) == GRID_WIDTH - 2) begin
                    n_x = XB'(1);
                    if (32'(r_y) == GRID_HEIGHT - 2) begin
                        n_y = YB'(1);
                        n_sweeps = r_sweeps + 1'b1;
                        n_chg = 1'b0;
                        if (!r_chg || r_sweeps == 16'hFFFE) begin
                            n_x = XB'(r_req.cell_x);
                            n_y = YB'(r_req.cell_y);
                            n_state = ST_RESULT;
                        end
                    end else begin
                        n_y = r_y + 1'b1;
                    end
                end else begin
                    n_x = r_x + 1'b1;
                end
            end
            ST_RESULT: begin
                mem_ra = addr_c;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                mem_ra = addr_c;
                if (!r_ovalid || i_ready) begin
                    n_rsp.cell_value = in_inside ? 16'($signed(r_rd[VB-1:0])) : '0;
                    n_rsp.direction = (r_req.func == FUNC_QUERY && in_interior) ?
                                      r_dir : DIR_NONE;
                    n_rsp.sweep_count = r_sweeps;
                    n_ovalid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule
